// ===== hdl/terrain_height_sample_unit_defines.svh =====
// assertion macros for the terrain height sample unit
`ifndef TERRAIN_HEIGHT_SAMPLE_UNIT_DEFINES_SVH
`define TERRAIN_HEIGHT_SAMPLE_UNIT_DEFINES_SVH

// condition implies consequence in the same cycle
`define THS_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// condition implies consequence in the next cycle
`define THS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/ths_pkg.sv =====
package ths_pkg;

    localparam int MAX_VERTICES = 65536;
    localparam int FRAC_BITS    = 8;

    localparam int IDX_W    = 16;
    localparam int CODE_W   = 8;
    localparam int POS_W    = 16;
    localparam int CFG_W    = 9;
    localparam int HEIGHT_W = 13;

    localparam int CELL_W = POS_W - FRAC_BITS;
    localparam int LIN_W  = CFG_W + CELL_W + 1;
    localparam int BANK_DEPTH = MAX_VERTICES / 2;
    localparam int BANK_AW    = $clog2(BANK_DEPTH);

    localparam int ONE    = 1 << FRAC_BITS;
    localparam int WT_W   = FRAC_BITS + 1;
    localparam int PROD_W = CODE_W + WT_W;
    localparam int SUM_W  = CODE_W + FRAC_BITS;

    // world height = code / 255 * 25.6, i.e. v * 2^15 / (1275 * 2^FRAC_BITS)
    localparam int SCALE_SHIFT = 15;
    localparam int SCALE_DEN   = 1275;
    localparam int WIDE_W      = SUM_W + SCALE_SHIFT;
    localparam int NUM_W       = WIDE_W - FRAC_BITS;

    localparam int RECIP_SHIFT = 32;
    localparam longint unsigned RECIP_FULL = (64'd1 << RECIP_SHIFT) / 64'(SCALE_DEN);
    localparam int RECIP_W = $clog2(RECIP_FULL);
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_FULL);
    localparam int MPROD_W = NUM_W + RECIP_W;

    localparam int HEIGHT_MAX = ((2 ** CODE_W - 1) * (2 ** SCALE_SHIFT)) / SCALE_DEN;

    localparam logic [CFG_W-1:0] GRID_RESET = CFG_W'(256);

    typedef enum logic [0:0] {
        OP_WRITE  = 1'b0,
        OP_SAMPLE = 1'b1
    } op_t;

    typedef enum logic [0:0] {
        REG_GRID_WIDTH = 1'b0,
        REG_GRID_DEPTH = 1'b1
    } cfg_reg_t;

endpackage

// ===== hdl/ths_ram.sv =====
module ths_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr_a,
    output logic [WIDTH-1:0] rd_data_a,
    input  logic [AW-1:0]    rd_addr_b,
    output logic [WIDTH-1:0] rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_a <= mem[rd_addr_a];
            rd_data_b <= mem[rd_addr_b];
        end
    end

endmodule

// ===== hdl/terrain_height_sample_unit.sv =====
// terrain height sample unit
// input channel (s_valid/s_ready) carries one request per cycle while ready: operation 0
// writes s_height_code at s_vertex_index, operation 1 samples the height at (s_pos_x,
// s_pos_z), both with 8 fraction bits. a write gives no result, a sample gives exactly
// one on the m_ channel: m_height_value (world units, 8 fraction bits) and m_in_range.
// the heights live in two banks split by vertex index parity, each with two read
// ports, so the four cell corners are read in the cycle a sample is taken.
// a sample passes stages 1 to 4, then the output register; throughput is one request
// per cycle unless stalled, set by the single write port and the five-stage datapath.
// a write is visible to any sample accepted in a later cycle.
// when the receiver stalls, the output holds and the stages behind it keep filling;
// s_ready drops only once every stage holds a sample. grid_width and grid_depth are
// written through cfg_wr_en/cfg_index/cfg_data; the user must do so only while idle, as
// the block does not enforce it. reset empties the pipeline and sets both grid registers
// to 256; the height store is not cleared and must be written before it is sampled.
`include "terrain_height_sample_unit_defines.svh"

module terrain_height_sample_unit (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_wr_en,
    input  logic [0:0]                   cfg_index,
    input  logic [ths_pkg::CFG_W-1:0]    cfg_data,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_operation,
    input  logic [ths_pkg::IDX_W-1:0]    s_vertex_index,
    input  logic [ths_pkg::CODE_W-1:0]   s_height_code,
    input  logic [ths_pkg::POS_W-1:0]    s_pos_x,
    input  logic [ths_pkg::POS_W-1:0]    s_pos_z,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [ths_pkg::HEIGHT_W-1:0] m_height_value,
    output logic                         m_in_range
);

    localparam int CELL_W   = ths_pkg::CELL_W;
    localparam int LIN_W    = ths_pkg::LIN_W;
    localparam int CFG_W    = ths_pkg::CFG_W;
    localparam int CODE_W   = ths_pkg::CODE_W;
    localparam int WT_W     = ths_pkg::WT_W;
    localparam int PROD_W   = ths_pkg::PROD_W;
    localparam int SUM_W    = ths_pkg::SUM_W;
    localparam int WIDE_W   = ths_pkg::WIDE_W;
    localparam int NUM_W    = ths_pkg::NUM_W;
    localparam int MPROD_W  = ths_pkg::MPROD_W;
    localparam int HEIGHT_W = ths_pkg::HEIGHT_W;
    localparam int BANK_AW  = ths_pkg::BANK_AW;
    localparam int FRAC     = ths_pkg::FRAC_BITS;

    logic [CFG_W-1:0] grid_width_reg;
    logic [CFG_W-1:0] grid_depth_reg;

    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg, m_valid_reg;
    logic adv1, adv2, adv3, adv4, out_ready;
    logic accept;

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_width_reg <= ths_pkg::GRID_RESET;
            grid_depth_reg <= ths_pkg::GRID_RESET;
        end else if (cfg_wr_en) begin
            if (cfg_index == ths_pkg::REG_GRID_WIDTH) begin
                grid_width_reg <= cfg_data;
            end else begin
                grid_depth_reg <= cfg_data;
            end
        end
    end

    // stage advance chain
    assign out_ready = !m_valid_reg || m_ready;
    assign adv4      = !s4_valid_reg || out_ready;
    assign adv3      = !s3_valid_reg || adv4;
    assign adv2      = !s2_valid_reg || adv3;
    assign adv1      = !s1_valid_reg || adv2;
    assign s_ready   = adv1;
    assign accept    = s_valid && adv1;

    // cell lookup
    logic [CELL_W-1:0]       cell_x, cell_z;
    logic [FRAC-1:0]         frac_x, frac_z;
    logic [CFG_W+CELL_W-1:0] row_base;
    logic [LIN_W-1:0]        idx00, idx00_p1, idx01, idx01_p1, idx11;
    logic                    in_range_c;
    logic [WT_W-1:0]         fsum, wt_a, wt_b, wt_c;
    logic                    lower_c;

    assign cell_x   = s_pos_x[ths_pkg::POS_W-1:FRAC];
    assign cell_z   = s_pos_z[ths_pkg::POS_W-1:FRAC];
    assign frac_x   = s_pos_x[FRAC-1:0];
    assign frac_z   = s_pos_z[FRAC-1:0];
    assign row_base = (CFG_W+CELL_W)'(grid_width_reg) * (CFG_W+CELL_W)'(cell_z);
    assign idx00    = LIN_W'(row_base) + LIN_W'(cell_x);
    assign idx00_p1 = idx00 + LIN_W'(1);
    assign idx01    = idx00 + LIN_W'(grid_width_reg);
    assign idx01_p1 = idx01 + LIN_W'(1);
    assign idx11    = idx01_p1;

    assign in_range_c = (LIN_W'(cell_x) + LIN_W'(1) < LIN_W'(grid_width_reg))
                     && (LIN_W'(cell_z) + LIN_W'(1) < LIN_W'(grid_depth_reg))
                     && (32'(idx11) < 32'(ths_pkg::MAX_VERTICES));

    assign fsum    = WT_W'(frac_x) + WT_W'(frac_z);
    assign lower_c = fsum <= WT_W'(ths_pkg::ONE);
    assign wt_a    = lower_c ? WT_W'(ths_pkg::ONE) - fsum : fsum - WT_W'(ths_pkg::ONE);
    assign wt_b    = lower_c ? WT_W'(frac_x) : WT_W'(ths_pkg::ONE) - WT_W'(frac_z);
    assign wt_c    = lower_c ? WT_W'(frac_z) : WT_W'(ths_pkg::ONE) - WT_W'(frac_x);

    // height banks, split by index parity
    logic               wr_ok, wr_even, wr_odd;
    logic [BANK_AW-1:0] wr_addr;
    logic [BANK_AW-1:0] even_addr_a, odd_addr_a, even_addr_b, odd_addr_b;
    logic [CODE_W-1:0]  even_a, odd_a, even_b, odd_b;

    assign wr_ok   = accept && (s_operation == ths_pkg::OP_WRITE)
                  && (32'(s_vertex_index) < 32'(ths_pkg::MAX_VERTICES));
    assign wr_even = wr_ok && !s_vertex_index[0];
    assign wr_odd  = wr_ok && s_vertex_index[0];
    assign wr_addr = BANK_AW'(s_vertex_index >> 1);

    assign even_addr_a = BANK_AW'(idx00_p1 >> 1);
    assign odd_addr_a  = BANK_AW'(idx00 >> 1);
    assign even_addr_b = BANK_AW'(idx01_p1 >> 1);
    assign odd_addr_b  = BANK_AW'(idx01 >> 1);

    ths_ram #(
        .WIDTH (CODE_W),
        .DEPTH (ths_pkg::BANK_DEPTH)
    ) u_even_bank (
        .aclk      (aclk),
        .wr_en     (wr_even),
        .wr_addr   (wr_addr),
        .wr_data   (s_height_code),
        .rd_en     (adv1),
        .rd_addr_a (even_addr_a),
        .rd_data_a (even_a),
        .rd_addr_b (even_addr_b),
        .rd_data_b (even_b)
    );

    ths_ram #(
        .WIDTH (CODE_W),
        .DEPTH (ths_pkg::BANK_DEPTH)
    ) u_odd_bank (
        .aclk      (aclk),
        .wr_en     (wr_odd),
        .wr_addr   (wr_addr),
        .wr_data   (s_height_code),
        .rd_en     (adv1),
        .rd_addr_a (odd_addr_a),
        .rd_data_a (odd_a),
        .rd_addr_b (odd_addr_b),
        .rd_data_b (odd_b)
    );

    // stage 1: read data arrives
    logic            s1_range_reg, s1_par0_reg, s1_par1_reg, s1_lower_reg;
    logic [WT_W-1:0] s1_wa_reg, s1_wb_reg, s1_wc_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (adv1) begin
            s1_valid_reg <= accept && (s_operation == ths_pkg::OP_SAMPLE);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv1) begin
            s1_range_reg <= in_range_c;
            s1_par0_reg  <= idx00[0];
            s1_par1_reg  <= idx01[0];
            s1_lower_reg <= lower_c;
            s1_wa_reg    <= wt_a;
            s1_wb_reg    <= wt_b;
            s1_wc_reg    <= wt_c;
        end
    end

    // stage 2: weighted corners
    logic [CODE_W-1:0] c00, c10, c01, c11, c_a;
    logic [PROD_W-1:0] s2_p0_reg, s2_p1_reg, s2_p2_reg;
    logic              s2_range_reg;

    assign c00 = s1_par0_reg ? odd_a  : even_a;
    assign c10 = s1_par0_reg ? even_a : odd_a;
    assign c01 = s1_par1_reg ? odd_b  : even_b;
    assign c11 = s1_par1_reg ? even_b : odd_b;
    assign c_a = s1_lower_reg ? c00 : c11;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (adv2) begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv2) begin
            s2_p0_reg    <= PROD_W'(c_a) * PROD_W'(s1_wa_reg);
            s2_p1_reg    <= PROD_W'(c10) * PROD_W'(s1_wb_reg);
            s2_p2_reg    <= PROD_W'(c01) * PROD_W'(s1_wc_reg);
            s2_range_reg <= s1_range_reg;
        end
    end

    // stage 3: sum and prescale
    logic [PROD_W+1:0] psum;
    logic [SUM_W-1:0]  vsum;
    logic [WIDE_W-1:0] wide;
    logic [NUM_W-1:0]  s3_num_reg;
    logic              s3_range_reg;

    assign psum = (PROD_W+2)'(s2_p0_reg) + (PROD_W+2)'(s2_p1_reg) + (PROD_W+2)'(s2_p2_reg);
    assign vsum = psum[SUM_W-1:0];
    assign wide = WIDE_W'(vsum) << ths_pkg::SCALE_SHIFT;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s3_valid_reg <= 1'b0;
        end else if (adv3) begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv3) begin
            s3_num_reg   <= NUM_W'(wide >> FRAC);
            s3_range_reg <= s2_range_reg;
        end
    end

    // stage 4: quotient estimate by reciprocal
    logic [MPROD_W-1:0]  mprod;
    logic [HEIGHT_W-1:0] s4_q0_reg;
    logic [NUM_W-1:0]    s4_num_reg;
    logic                s4_range_reg;

    assign mprod = MPROD_W'(s3_num_reg) * MPROD_W'(ths_pkg::RECIP);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s4_valid_reg <= 1'b0;
        end else if (adv4) begin
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv4) begin
            s4_q0_reg    <= mprod[ths_pkg::RECIP_SHIFT +: HEIGHT_W];
            s4_num_reg   <= s3_num_reg;
            s4_range_reg <= s3_range_reg;
        end
    end

    // output stage: one-step correction
    logic [NUM_W-1:0]    rem_full;
    logic [HEIGHT_W-1:0] height_next;
    logic [HEIGHT_W-1:0] m_height_value_reg;
    logic                m_in_range_reg;

    assign rem_full = s4_num_reg - NUM_W'(s4_q0_reg) * NUM_W'(ths_pkg::SCALE_DEN);

    always_comb begin
        height_next = s4_q0_reg;
        if (rem_full >= NUM_W'(ths_pkg::SCALE_DEN)) begin
            height_next = s4_q0_reg + HEIGHT_W'(1);
        end
        if (!s4_range_reg) begin
            height_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_ready) begin
            m_valid_reg <= s4_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_ready) begin
            m_height_value_reg <= height_next;
            m_in_range_reg     <= s4_range_reg;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_height_value = m_height_value_reg;
    assign m_in_range     = m_in_range_reg;

    `THS_ASSERT_IMPLIES(a_oor_zero, m_valid && !m_in_range, m_height_value == '0,
        "out of range result not zero")
    `THS_ASSERT_IMPLIES(a_height_bound, m_valid,
        m_height_value <= HEIGHT_W'(ths_pkg::HEIGHT_MAX), "height above scale maximum")
    `THS_ASSERT_NEXT(a_write_no_item, accept && (s_operation == ths_pkg::OP_WRITE),
        !s1_valid_reg, "write request entered datapath")
    `THS_ASSERT_IMPLIES(a_rem_bound, s4_valid_reg && s4_range_reg,
        rem_full < NUM_W'(2 * ths_pkg::SCALE_DEN), "reciprocal estimate off by more than one")

endmodule

// ===== bench/terrain_height_sample_unit_test.sv =====
module terrain_height_sample_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import ths_pkg::*;

    typedef struct packed {
        logic [HEIGHT_W-1:0] height;
        logic                in_range;
    } height_result_t;

    logic                aclk           = 1'b0;
    logic                aresetn        = 1'b0;
    logic                cfg_wr_en      = 1'b0;
    logic [0:0]          cfg_index      = REG_GRID_WIDTH;
    logic [CFG_W-1:0]    cfg_data       = '0;
    logic                s_valid        = 1'b0;
    logic                s_ready;
    logic                s_operation    = OP_WRITE;
    logic [IDX_W-1:0]    s_vertex_index = '0;
    logic [CODE_W-1:0]   s_height_code  = '0;
    logic [POS_W-1:0]    s_pos_x        = '0;
    logic [POS_W-1:0]    s_pos_z        = '0;
    logic                m_valid;
    logic                m_ready        = 1'b0;
    logic [HEIGHT_W-1:0] m_height_value;
    logic                m_in_range;

    bit [CODE_W-1:0]     height_mirror [MAX_VERTICES];
    bit                  vertex_loaded [MAX_VERTICES];
    logic [CFG_W-1:0]    grid_width_mirror = GRID_RESET;
    logic [CFG_W-1:0]    grid_depth_mirror = GRID_RESET;
    height_result_t      pending_heights [$];
    height_result_t      oldest_height;
    int                  mismatch_count = 0;
    int                  burst_left     = 0;
    bit                  sender_gaps    = 1'b1;
    int                  rx_mode        = 0;
    int                  rx_phase_left  = 0;
    int                  rx_stall_left  = 0;
    int unsigned         rx_cycle       = 0;

    terrain_height_sample_unit dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_operation    (s_operation),
        .s_vertex_index (s_vertex_index),
        .s_height_code  (s_height_code),
        .s_pos_x        (s_pos_x),
        .s_pos_z        (s_pos_z),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_height_value (m_height_value),
        .m_in_range     (m_in_range)
    );

    always #1 aclk = ~aclk;

    function automatic bit locate_cell(input logic [POS_W-1:0] px, input logic [POS_W-1:0] pz,
                                       output longint unsigned base);
        longint unsigned cx, cz, w;
        cx   = px >> FRAC_BITS;
        cz   = pz >> FRAC_BITS;
        w    = grid_width_mirror;
        base = w * cz + cx;
        return !(cx + 1 >= grid_width_mirror || cz + 1 >= grid_depth_mirror ||
                 w * (cz + 1) + cx + 1 >= MAX_VERTICES);
    endfunction

    function automatic height_result_t predict_height(input logic [POS_W-1:0] px,
                                                      input logic [POS_W-1:0] pz);
        longint unsigned base, w, fx, fz, v, c00, c10, c01, c11;
        height_result_t r;
        r = '0;
        if (!locate_cell(px, pz, base))
            return r;
        w   = grid_width_mirror;
        fx  = px & (ONE - 1);
        fz  = pz & (ONE - 1);
        c00 = height_mirror[base];
        c10 = height_mirror[base + 1];
        c01 = height_mirror[base + w];
        c11 = height_mirror[base + w + 1];
        // lower triangle when fx + fz <= 1, else upper
        if (fx + fz <= ONE)
            v = c00 * (ONE - fx - fz) + c10 * fx + c01 * fz;
        else
            v = c11 * (fx + fz - ONE) + c01 * (ONE - fx) + c10 * (ONE - fz);
        r.height   = HEIGHT_W'((v << SCALE_SHIFT) / (SCALE_DEN * ONE));
        r.in_range = 1'b1;
        return r;
    endfunction

    function automatic void note_failure(input string what);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("mismatch at %0t: %s", $realtime, what);
    endfunction

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_heights.size() == 0) begin
                note_failure($sformatf("unexpected result height %0d in_range %0b",
                                       m_height_value, m_in_range));
            end else begin
                oldest_height = pending_heights.pop_front();
                if (m_height_value !== oldest_height.height ||
                    m_in_range !== oldest_height.in_range)
                    note_failure($sformatf("expected height %0d in_range %0b, got %0d %0b",
                                           oldest_height.height, oldest_height.in_range,
                                           m_height_value, m_in_range));
            end
        end
        if (rx_phase_left == 0) begin
            rx_mode       = $urandom_range(0, 3);
            rx_phase_left = $urandom_range(50, 300);
        end
        rx_phase_left--;
        rx_cycle++;
        case (rx_mode)
            0: m_ready <= 1'b1;
            1: m_ready <= 1'($urandom_range(0, 1));
            2: m_ready <= (rx_cycle % 4 != 0);
            default: begin
                if (rx_stall_left > 0) begin
                    m_ready <= 1'b0;
                    rx_stall_left--;
                end else begin
                    m_ready <= 1'b1;
                    if ($urandom_range(0, 7) == 0)
                        rx_stall_left = $urandom_range(2, 12);
                end
            end
        endcase
    end

    task automatic send_request(input op_t op, input logic [IDX_W-1:0] idx,
                                input logic [CODE_W-1:0] code,
                                input logic [POS_W-1:0] px, input logic [POS_W-1:0] pz);
        int gap;
        if (burst_left == 0) begin
            gap = (!sender_gaps || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        s_valid        <= 1'b1;
        s_operation    <= op;
        s_vertex_index <= idx;
        s_height_code  <= code;
        s_pos_x        <= px;
        s_pos_z        <= pz;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (op == OP_WRITE) begin
            height_mirror[idx] = code;
            vertex_loaded[idx] = 1'b1;
        end else begin
            pending_heights.push_back(predict_height(px, pz));
        end
    endtask

    task automatic write_vertex(input logic [IDX_W-1:0] idx, input logic [CODE_W-1:0] code);
        send_request(OP_WRITE, idx, code, POS_W'($urandom), POS_W'($urandom));
    endtask

    // load any corner of the cell that was never written before sampling it
    task automatic sample_at(input logic [POS_W-1:0] px, input logic [POS_W-1:0] pz);
        longint unsigned base, w, corner;
        int k;
        w = grid_width_mirror;
        if (locate_cell(px, pz, base)) begin
            for (k = 0; k < 4; k++) begin
                corner = base + (k & 1) + ((k >> 1) != 0 ? w : 0);
                if (!vertex_loaded[corner])
                    write_vertex(IDX_W'(corner), CODE_W'($urandom));
            end
        end
        send_request(OP_SAMPLE, IDX_W'($urandom), CODE_W'($urandom), px, pz);
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        while (pending_heights.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        burst_left = 0;
    endtask

    task automatic write_grid(input cfg_reg_t which, input logic [CFG_W-1:0] value);
        settle();
        cfg_wr_en <= 1'b1;
        cfg_index <= which;
        cfg_data  <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (which == REG_GRID_WIDTH)
            grid_width_mirror = value;
        else
            grid_depth_mirror = value;
    endtask

    task automatic set_grid(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] d);
        write_grid(REG_GRID_WIDTH, w);
        write_grid(REG_GRID_DEPTH, d);
    endtask

    function automatic logic [POS_W-1:0] pick_coord(input logic [CFG_W-1:0] extent);
        int cell_num;
        logic [FRAC_BITS-1:0] frac;
        case ($urandom_range(0, 9))
            0: return POS_W'($urandom);
            1: cell_num = (extent == 0) ? 0 : extent - 1;
            default: cell_num = (extent >= 2) ? $urandom_range(0, extent - 2) : 0;
        endcase
        if (cell_num > 255)
            cell_num = 255;
        case ($urandom_range(0, 5))
            0: frac = '0;
            1: frac = '1;
            default: frac = FRAC_BITS'($urandom);
        endcase
        return {8'(cell_num), frac};
    endfunction

    task automatic test_reset_grid();
        write_vertex(16'd0, 8'd0);
        write_vertex(16'd1, 8'd255);
        write_vertex(16'd256, 8'd255);
        write_vertex(16'd257, 8'd0);
        sample_at(16'h0000, 16'h0000);
        sample_at(16'h0080, 16'h0080);
        sample_at(16'h00FF, 16'h00FF);
        sample_at(16'h0100, 16'h0000);
        write_vertex(16'd65535, 8'd255);
        write_vertex(16'd65534, 8'd255);
        write_vertex(16'd65279, 8'd255);
        write_vertex(16'd65278, 8'd255);
        sample_at(16'hFEFF, 16'hFEFF);
        sample_at(16'hFE00, 16'hFE00);
        sample_at(16'hFF00, 16'h0000);
        sample_at(16'h0000, 16'hFF00);
        sample_at(16'hFFFF, 16'hFFFF);
    endtask

    task automatic test_register_extremes();
        set_grid(9'd0, 9'd256);
        sample_at(16'h0000, 16'h0000);
        set_grid(9'd1, 9'd1);
        sample_at(16'h0000, 16'h0000);
        set_grid(9'd2, 9'd2);
        write_vertex(16'd0, 8'd255);
        write_vertex(16'd1, 8'd0);
        write_vertex(16'd2, 8'd128);
        write_vertex(16'd3, 8'd1);
        sample_at(16'h0080, 16'h0080);
        sample_at(16'h00FF, 16'h00FF);
        sample_at(16'h0100, 16'h0000);
        set_grid(9'd511, 9'd2);
        sample_at(16'hFE40, 16'h0020);
        set_grid(9'd256, 9'd511);
        sample_at(16'h0000, 16'hFF10);
        sample_at(16'hFE80, 16'hFE30);
    endtask

    task automatic test_random_grids();
        logic [CFG_W-1:0] widths [8];
        logic [CFG_W-1:0] depths [8];
        longint unsigned span;
        logic [POS_W-1:0] px, pz;
        logic [CODE_W-1:0] code;
        int ph, n, pick;
        widths = '{9'd256, 9'd2, 9'd5, 9'd256, 9'd2, 9'd0, 9'd300, 9'd511};
        depths = '{9'd256, 9'd2, 9'd3, 9'd2, 9'd256, 9'd0, 9'd200, 9'd511};
        widths[5] = CFG_W'($urandom_range(2, 256));
        depths[5] = CFG_W'($urandom_range(2, 256));
        for (ph = 0; ph < 8; ph++) begin
            set_grid(widths[ph], depths[ph]);
            sender_gaps = ($urandom_range(0, 3) != 0);
            span = longint'(grid_width_mirror) * grid_depth_mirror;
            if (span > MAX_VERTICES)
                span = MAX_VERTICES;
            for (n = 0; n < 80; n++) begin
                pick = $urandom_range(0, 99);
                case ($urandom_range(0, 5))
                    0: code = '0;
                    1: code = '1;
                    default: code = CODE_W'($urandom);
                endcase
                if (pick < 15 && span > 0) begin
                    write_vertex(IDX_W'($urandom_range(0, span - 1)), code);
                end else if (pick < 20) begin
                    write_vertex(IDX_W'($urandom), code);
                end else begin
                    px = pick_coord(grid_width_mirror);
                    pz = pick_coord(grid_depth_mirror);
                    // land exactly on the diagonal between the two triangles
                    if ($urandom_range(0, 7) == 0 && px[FRAC_BITS-1:0] != 0)
                        pz[FRAC_BITS-1:0] = FRAC_BITS'(ONE - px[FRAC_BITS-1:0]);
                    sample_at(px, pz);
                end
            end
        end
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_grid();
        test_register_extremes();
        test_random_grids();
        settle();
        repeat (20) @(posedge aclk);
        if (mismatch_count == 0 && pending_heights.size() == 0) begin
            $display("[terrain_height_sample_unit] OK");
        end else begin
            $display("[terrain_height_sample_unit] ERROR");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("[terrain_height_sample_unit] ERROR");
        $finish;
    end

endmodule
